@@ design/pthc_pkg.sv @@
// Shared types, widths and constants for the point transform and height colour unit.
// Depends on nothing; every other design file refers to it by scoped names.

package pthc_pkg;

    // Field formats.
    localparam int COORD_W         = 32;
    localparam int QUAT_W          = 16;
    localparam int QUAT_FRAC       = 14;
    localparam int COORD_FRAC_BITS = 16;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int LEVEL_W         = 8;

    // Internal widths of the rotation datapath, each just wide enough to be exact.
    localparam int PROD_W  = QUAT_W + COORD_W;       // q * v
    localparam int CROSS_W = PROD_W + 1;             // q x v
    localparam int T_SHIFT = QUAT_FRAC - 1;          // t = 2 * (q x v), rounded
    localparam int T_W     = CROSS_W - T_SHIFT;
    localparam int RPROD_W = QUAT_W + T_W;           // q * t
    localparam int RSUM_W  = RPROD_W + 2;            // w*t + q x t
    localparam int ROT_W   = RSUM_W - QUAT_FRAC;
    localparam int WIDE_W  = ROT_W + 2;              // v + rotated term + shift
    localparam int DIFF_W  = WIDE_W + 1;             // height above the floor
    localparam int NUM_W   = DIFF_W + 1;             // span minus that height
    localparam int SPAN_W  = COORD_W + 1;

    // Colour divider: 2 * 255 * num / span, one quotient bit per stage.
    localparam int DIV_STEPS   = LEVEL_W;
    localparam int DEN_W       = COORD_W;
    localparam int NUMER_W     = COORD_W + DIV_STEPS;
    localparam int LEVEL_SCALE = 510;

    // Pipeline depths.
    localparam int ROT_STAGES = 5;
    localparam int LEVEL_LAT  = DIV_STEPS + 1;
    localparam int PIPE_DEPTH = ROT_STAGES + 1 + LEVEL_LAT + 1;

    localparam logic [LEVEL_W-1:0]        LEVEL_FULL = '1;
    localparam logic signed [COORD_W-1:0] COORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN  = 32'sh8000_0000;

    // Reset values: unit quaternion, colour span of one metre.
    localparam logic [CFG_W-1:0] CFG_ROT_WX_RESET   = CFG_W'(1) << (QUAT_W + QUAT_FRAC);
    localparam logic [CFG_W-1:0] CFG_CEILING_RESET  = CFG_W'(1) << COORD_FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_WX,
        CFG_ROT_YZ,
        CFG_SHIFT_X,
        CFG_SHIFT_Y,
        CFG_SHIFT_Z,
        CFG_FLOOR,
        CFG_CEILING
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] local_x;
        logic signed [COORD_W-1:0] local_y;
        logic signed [COORD_W-1:0] local_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
        logic [LEVEL_W-1:0]        red_level;
        logic [LEVEL_W-1:0]        green_level;
        logic                      coord_saturated;
    } result_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0]  quat_w;
        logic signed [QUAT_W-1:0]  quat_x;
        logic signed [QUAT_W-1:0]  quat_y;
        logic signed [QUAT_W-1:0]  quat_z;
        logic signed [COORD_W-1:0] shift_x;
        logic signed [COORD_W-1:0] shift_y;
        logic signed [COORD_W-1:0] shift_z;
        logic signed [COORD_W-1:0] color_floor;
        logic signed [COORD_W-1:0] color_ceiling;
    } cfg_t;

    typedef struct packed {
        logic signed [WIDE_W-1:0] wx;
        logic signed [WIDE_W-1:0] wy;
        logic signed [WIDE_W-1:0] wz;
    } wide_point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
        logic                      coord_saturated;
    } world_t;

endpackage

@@ design/pthc_rotate.sv @@
// Five-stage quaternion rotation and translation of one point per cycle.
// Depends on pthc_pkg for the point, configuration and wide point types.

module pthc_rotate (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  pthc_pkg::point_t      point,
    input  pthc_pkg::cfg_t        cfg,
    output logic                  out_valid,
    output pthc_pkg::wide_point_t world
);

    localparam int PROD_W     = pthc_pkg::PROD_W;
    localparam int CROSS_W    = pthc_pkg::CROSS_W;
    localparam int T_SHIFT    = pthc_pkg::T_SHIFT;
    localparam int T_W        = pthc_pkg::T_W;
    localparam int RPROD_W    = pthc_pkg::RPROD_W;
    localparam int RSUM_W     = pthc_pkg::RSUM_W;
    localparam int ROT_W      = pthc_pkg::ROT_W;
    localparam int WIDE_W     = pthc_pkg::WIDE_W;
    localparam int QUAT_FRAC  = pthc_pkg::QUAT_FRAC;
    localparam int ROT_STAGES = pthc_pkg::ROT_STAGES;
    localparam int T_HALF     = 1 << (T_SHIFT - 1);
    localparam int R_HALF     = 1 << (QUAT_FRAC - 1);

    logic [ROT_STAGES-1:0] vld_reg, vld_next;

    // Stage 1: the six products of q x v.
    logic signed [PROD_W-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    logic signed [PROD_W-1:0] p_yz_next, p_zy_next, p_zx_next, p_xz_next, p_xy_next, p_yx_next;
    pthc_pkg::point_t pt1_reg, pt2_reg, pt3_reg, pt4_reg;

    // Stage 2: t = 2 * (q x v), rounded to coordinate units.
    logic signed [CROSS_W-1:0] c_x, c_y, c_z, c_x_rnd, c_y_rnd, c_z_rnd;
    logic signed [T_W-1:0]     tx_reg, ty_reg, tz_reg, tx_next, ty_next, tz_next;

    // Stage 3: the nine products of w*t and q x t.
    logic signed [RPROD_W-1:0] mw_x_reg, mw_y_reg, mw_z_reg, mw_x_next, mw_y_next, mw_z_next;
    logic signed [RPROD_W-1:0] ma_x_reg, ma_y_reg, ma_z_reg, ma_x_next, ma_y_next, ma_z_next;
    logic signed [RPROD_W-1:0] mb_x_reg, mb_y_reg, mb_z_reg, mb_x_next, mb_y_next, mb_z_next;

    // Stage 4: summed rotation term.
    logic signed [RSUM_W-1:0] r_x_reg, r_y_reg, r_z_reg, r_x_next, r_y_next, r_z_next;

    // Stage 5: rounded term plus point plus translation.
    logic signed [RSUM_W-1:0] r_x_rnd, r_y_rnd, r_z_rnd;
    logic signed [ROT_W-1:0]  rot_x, rot_y, rot_z;
    pthc_pkg::wide_point_t    world_reg, world_next;

    assign vld_next = {vld_reg[ROT_STAGES-2:0], in_valid};

    always_comb
    begin
        p_yz_next = PROD_W'(cfg.quat_y) * PROD_W'(point.local_z);
        p_zy_next = PROD_W'(cfg.quat_z) * PROD_W'(point.local_y);
        p_zx_next = PROD_W'(cfg.quat_z) * PROD_W'(point.local_x);
        p_xz_next = PROD_W'(cfg.quat_x) * PROD_W'(point.local_z);
        p_xy_next = PROD_W'(cfg.quat_x) * PROD_W'(point.local_y);
        p_yx_next = PROD_W'(cfg.quat_y) * PROD_W'(point.local_x);
    end

    always_comb
    begin
        c_x     = CROSS_W'(p_yz_reg) - CROSS_W'(p_zy_reg);
        c_y     = CROSS_W'(p_zx_reg) - CROSS_W'(p_xz_reg);
        c_z     = CROSS_W'(p_xy_reg) - CROSS_W'(p_yx_reg);
        c_x_rnd = c_x + CROSS_W'(T_HALF);
        c_y_rnd = c_y + CROSS_W'(T_HALF);
        c_z_rnd = c_z + CROSS_W'(T_HALF);
        // Dropping the low bits of a two's complement word is a floor.
        tx_next = c_x_rnd[CROSS_W-1:T_SHIFT];
        ty_next = c_y_rnd[CROSS_W-1:T_SHIFT];
        tz_next = c_z_rnd[CROSS_W-1:T_SHIFT];
    end

    always_comb
    begin
        mw_x_next = RPROD_W'(cfg.quat_w) * RPROD_W'(tx_reg);
        mw_y_next = RPROD_W'(cfg.quat_w) * RPROD_W'(ty_reg);
        mw_z_next = RPROD_W'(cfg.quat_w) * RPROD_W'(tz_reg);
        ma_x_next = RPROD_W'(cfg.quat_y) * RPROD_W'(tz_reg);
        mb_x_next = RPROD_W'(cfg.quat_z) * RPROD_W'(ty_reg);
        ma_y_next = RPROD_W'(cfg.quat_z) * RPROD_W'(tx_reg);
        mb_y_next = RPROD_W'(cfg.quat_x) * RPROD_W'(tz_reg);
        ma_z_next = RPROD_W'(cfg.quat_x) * RPROD_W'(ty_reg);
        mb_z_next = RPROD_W'(cfg.quat_y) * RPROD_W'(tx_reg);
    end

    always_comb
    begin
        r_x_next = RSUM_W'(mw_x_reg) + RSUM_W'(ma_x_reg) - RSUM_W'(mb_x_reg);
        r_y_next = RSUM_W'(mw_y_reg) + RSUM_W'(ma_y_reg) - RSUM_W'(mb_y_reg);
        r_z_next = RSUM_W'(mw_z_reg) + RSUM_W'(ma_z_reg) - RSUM_W'(mb_z_reg);
    end

    always_comb
    begin
        r_x_rnd       = r_x_reg + RSUM_W'(R_HALF);
        r_y_rnd       = r_y_reg + RSUM_W'(R_HALF);
        r_z_rnd       = r_z_reg + RSUM_W'(R_HALF);
        rot_x         = r_x_rnd[RSUM_W-1:QUAT_FRAC];
        rot_y         = r_y_rnd[RSUM_W-1:QUAT_FRAC];
        rot_z         = r_z_rnd[RSUM_W-1:QUAT_FRAC];
        world_next.wx = WIDE_W'(pt4_reg.local_x) + WIDE_W'(rot_x) + WIDE_W'(cfg.shift_x);
        world_next.wy = WIDE_W'(pt4_reg.local_y) + WIDE_W'(rot_y) + WIDE_W'(cfg.shift_y);
        world_next.wz = WIDE_W'(pt4_reg.local_z) + WIDE_W'(rot_z) + WIDE_W'(cfg.shift_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_yz_reg  <= p_yz_next;
        p_zy_reg  <= p_zy_next;
        p_zx_reg  <= p_zx_next;
        p_xz_reg  <= p_xz_next;
        p_xy_reg  <= p_xy_next;
        p_yx_reg  <= p_yx_next;
        pt1_reg   <= point;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        tz_reg    <= tz_next;
        pt2_reg   <= pt1_reg;
        mw_x_reg  <= mw_x_next;
        mw_y_reg  <= mw_y_next;
        mw_z_reg  <= mw_z_next;
        ma_x_reg  <= ma_x_next;
        ma_y_reg  <= ma_y_next;
        ma_z_reg  <= ma_z_next;
        mb_x_reg  <= mb_x_next;
        mb_y_reg  <= mb_y_next;
        mb_z_reg  <= mb_z_next;
        pt3_reg   <= pt2_reg;
        r_x_reg   <= r_x_next;
        r_y_reg   <= r_y_next;
        r_z_reg   <= r_z_next;
        pt4_reg   <= pt3_reg;
        world_reg <= world_next;
    end

    assign out_valid = vld_reg[ROT_STAGES-1];
    assign world     = world_reg;

endmodule

@@ design/pthc_level_div.sv @@
// One colour lane: classifies the height against the span, then a pipelined
// restoring divider yields one quotient bit per stage. Depends on pthc_pkg.

module pthc_level_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [pthc_pkg::NUM_W-1:0]    num,
    input  logic signed [pthc_pkg::SPAN_W-1:0]   span,
    input  logic                                 empty_full,
    output logic                                 out_valid,
    output logic [pthc_pkg::LEVEL_W-1:0]         level
);

    localparam int NUM_W     = pthc_pkg::NUM_W;
    localparam int SPAN_W    = pthc_pkg::SPAN_W;
    localparam int DEN_W     = pthc_pkg::DEN_W;
    localparam int NUMER_W   = pthc_pkg::NUMER_W;
    localparam int LEVEL_W   = pthc_pkg::LEVEL_W;
    localparam int DIV_STEPS = pthc_pkg::DIV_STEPS;

    logic [DIV_STEPS:0] vld_reg, vld_next;

    logic [NUMER_W-1:0] rem_reg  [0:DIV_STEPS];
    logic [NUMER_W-1:0] rem_next [0:DIV_STEPS];
    logic [DEN_W-1:0]   den_reg  [0:DIV_STEPS];
    logic [DEN_W-1:0]   den_next [0:DIV_STEPS];
    logic [LEVEL_W-1:0] q_reg    [0:DIV_STEPS];
    logic [LEVEL_W-1:0] q_next   [0:DIV_STEPS];
    logic               full_reg [0:DIV_STEPS];
    logic               full_next[0:DIV_STEPS];

    logic                     span_empty;
    logic                     num_empty;
    logic                     num_full;
    logic signed [NUM_W:0]    twice_num;
    logic [NUMER_W-1:0]       trial    [1:DIV_STEPS];
    logic                     take     [1:DIV_STEPS];

    assign vld_next = {vld_reg[DIV_STEPS-1:0], in_valid};

    // Classification: an empty span, a num at or below zero or at least half the
    // span, or a real division of 510 * num by the span. The quotient stages follow.
    always_comb
    begin
        span_empty   = span[SPAN_W-1] || (span == '0);
        num_empty    = num[NUM_W-1] || (num == '0);
        twice_num    = {num, 1'b0};
        num_full     = twice_num >= (NUM_W + 1)'(span);
        rem_next[0]  = '0;
        den_next[0]  = DEN_W'(1);
        q_next[0]    = '0;
        full_next[0] = 1'b0;
        if (span_empty)
        begin
            full_next[0] = empty_full;
        end
        else if (num_empty)
        begin
            full_next[0] = 1'b0;
        end
        else if (num_full)
        begin
            full_next[0] = 1'b1;
        end
        else
        begin
            // Here num is below half the span, so it fits the low word.
            rem_next[0] = NUMER_W'(num[DEN_W-1:0]) * NUMER_W'(pthc_pkg::LEVEL_SCALE);
            den_next[0] = span[DEN_W-1:0];
        end

        for (int s = 1; s <= DIV_STEPS; s++)
        begin
            trial[s]     = NUMER_W'(den_reg[s-1]) << (DIV_STEPS - s);
            take[s]      = rem_reg[s-1] >= trial[s];
            rem_next[s]  = take[s] ? rem_reg[s-1] - trial[s] : rem_reg[s-1];
            q_next[s]    = q_reg[s-1] |
                           (take[s] ? (LEVEL_W'(1) << (DIV_STEPS - s)) : LEVEL_W'(0));
            den_next[s]  = den_reg[s-1];
            full_next[s] = full_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= DIV_STEPS; s++)
        begin
            rem_reg[s]  <= rem_next[s];
            den_reg[s]  <= den_next[s];
            q_reg[s]    <= q_next[s];
            full_reg[s] <= full_next[s];
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign level     = full_reg[DIV_STEPS] ? pthc_pkg::LEVEL_FULL : q_reg[DIV_STEPS];

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STEPS] |-> (rem_reg[DIV_STEPS] < NUMER_W'(den_reg[DIV_STEPS])))
        else $error("colour divider left a remainder not below the divisor");

    a_quotient_short: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DIV_STEPS] && !full_reg[DIV_STEPS]) |->
            (q_reg[DIV_STEPS] != pthc_pkg::LEVEL_FULL))
        else $error("divided colour level reached full scale");

endmodule

@@ design/pthc_height_color.sv @@
// World coordinate saturation and the red and green height colour lanes.
// Depends on pthc_pkg and pthc_level_div.

module pthc_height_color (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  pthc_pkg::wide_point_t world,
    input  pthc_pkg::cfg_t        cfg,
    output logic                  out_valid,
    output pthc_pkg::result_t     result
);

    localparam int COORD_W   = pthc_pkg::COORD_W;
    localparam int WIDE_W    = pthc_pkg::WIDE_W;
    localparam int SPAN_W    = pthc_pkg::SPAN_W;
    localparam int DIFF_W    = pthc_pkg::DIFF_W;
    localparam int NUM_W     = pthc_pkg::NUM_W;
    localparam int LEVEL_W   = pthc_pkg::LEVEL_W;
    localparam int LEVEL_LAT = pthc_pkg::LEVEL_LAT;

    // Returns the saturation flag above the clamped 32-bit coordinate.
    function automatic logic [COORD_W:0] sat_coord(input logic signed [WIDE_W-1:0] w);
        logic fits;
        fits = (w[WIDE_W-1:COORD_W-1] == '0) || (w[WIDE_W-1:COORD_W-1] == '1);
        if (fits)
            return {1'b0, w[COORD_W-1:0]};
        else if (w[WIDE_W-1])
            return {1'b1, pthc_pkg::COORD_MIN};
        else
            return {1'b1, pthc_pkg::COORD_MAX};
    endfunction

    logic                      vld_a_reg;
    pthc_pkg::world_t          wa_reg, wa_next;
    logic signed [SPAN_W-1:0]  span_reg, span_next;
    logic signed [NUM_W-1:0]   red_num_reg, red_num_next;
    logic signed [NUM_W-1:0]   green_num_reg, green_num_next;
    logic signed [DIFF_W-1:0]  height;
    logic [COORD_W:0]          sat_x, sat_y, sat_z;

    pthc_pkg::world_t          dly_reg [0:LEVEL_LAT-1];

    logic                      red_valid, green_valid;
    logic [LEVEL_W-1:0]        red_level, green_level;

    always_comb
    begin
        sat_x                   = sat_coord(world.wx);
        sat_y                   = sat_coord(world.wy);
        sat_z                   = sat_coord(world.wz);
        wa_next.world_x         = sat_x[COORD_W-1:0];
        wa_next.world_y         = sat_y[COORD_W-1:0];
        wa_next.world_z         = sat_z[COORD_W-1:0];
        wa_next.coord_saturated = sat_x[COORD_W] | sat_y[COORD_W] | sat_z[COORD_W];
        // The colour follows the exact height, not the clamped one.
        span_next      = SPAN_W'(cfg.color_ceiling) - SPAN_W'(cfg.color_floor);
        height         = DIFF_W'(world.wz) - DIFF_W'(cfg.color_floor);
        red_num_next   = NUM_W'(span_next) - NUM_W'(height);
        green_num_next = NUM_W'(height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg        <= wa_next;
        span_reg      <= span_next;
        red_num_reg   <= red_num_next;
        green_num_reg <= green_num_next;
        dly_reg[0]    <= wa_reg;
        for (int i = 1; i < LEVEL_LAT; i++)
        begin
            dly_reg[i] <= dly_reg[i-1];
        end
    end

    // An empty span gives full red and no green.
    pthc_level_div u_red (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vld_a_reg),
        .num        (red_num_reg),
        .span       (span_reg),
        .empty_full (1'b1),
        .out_valid  (red_valid),
        .level      (red_level)
    );

    pthc_level_div u_green (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vld_a_reg),
        .num        (green_num_reg),
        .span       (span_reg),
        .empty_full (1'b0),
        .out_valid  (green_valid),
        .level      (green_level)
    );

    always_comb
    begin
        result.world_x         = dly_reg[LEVEL_LAT-1].world_x;
        result.world_y         = dly_reg[LEVEL_LAT-1].world_y;
        result.world_z         = dly_reg[LEVEL_LAT-1].world_z;
        result.coord_saturated = dly_reg[LEVEL_LAT-1].coord_saturated;
        result.red_level       = red_level;
        result.green_level     = green_level;
    end

    assign out_valid = red_valid & green_valid;

endmodule

@@ design/point_transform_height_color_unit.sv @@
// Top level of the point transform and height colour unit: configuration
// registers, the rotation pipeline, the colour pipeline and the result register.
// Depends on pthc_pkg, pthc_rotate and pthc_height_color.
//
//   Channel   Handshake           Payload                     Width
//   point     start / busy        point (point_t)             96
//   result    done (strobe only)  result (result_t)           113
//   config    cfg_we              cfg_index, cfg_wdata        3 + 32
//
// One point is taken every cycle; busy stays low.
// Each result appears on done after its start beat has passed through five
// rotation stages, one saturation stage, the nine-stage colour divider (a
// classification stage, then one quotient bit a stage) and the result register.
// Reset clears the pipeline valid bits and loads the configuration defaults.
// Results cannot be held off, so nothing in the pipeline ever waits.

module point_transform_height_color_unit #(
    parameter int COORD_FRAC_BITS = pthc_pkg::COORD_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pthc_pkg::point_t                  point,
    output logic                              done,
    output pthc_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [pthc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pthc_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int CFG_W      = pthc_pkg::CFG_W;
    localparam int QUAT_W     = pthc_pkg::QUAT_W;
    localparam int PIPE_DEPTH = pthc_pkg::PIPE_DEPTH;

    logic [CFG_W-1:0] rot_wx_reg, rot_yz_reg;
    logic [CFG_W-1:0] shift_x_reg, shift_y_reg, shift_z_reg;
    logic [CFG_W-1:0] floor_reg, ceiling_reg;

    pthc_pkg::cfg_t        cfg;
    logic                  accept;
    logic                  rot_valid;
    pthc_pkg::wide_point_t rot_world;
    logic                  col_valid;
    pthc_pkg::result_t     col_result;

    logic                  done_reg, done_next;
    pthc_pkg::result_t     result_reg, result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_wx_reg  <= pthc_pkg::CFG_ROT_WX_RESET;
            rot_yz_reg  <= '0;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            shift_z_reg <= '0;
            floor_reg   <= '0;
            // The ceiling resets to one metre in the coordinate format.
            ceiling_reg <= CFG_W'(1) << COORD_FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pthc_pkg::CFG_ROT_WX:  rot_wx_reg  <= cfg_wdata;
                pthc_pkg::CFG_ROT_YZ:  rot_yz_reg  <= cfg_wdata;
                pthc_pkg::CFG_SHIFT_X: shift_x_reg <= cfg_wdata;
                pthc_pkg::CFG_SHIFT_Y: shift_y_reg <= cfg_wdata;
                pthc_pkg::CFG_SHIFT_Z: shift_z_reg <= cfg_wdata;
                pthc_pkg::CFG_FLOOR:   floor_reg   <= cfg_wdata;
                pthc_pkg::CFG_CEILING: ceiling_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.quat_w        = rot_wx_reg[CFG_W-1:QUAT_W];
        cfg.quat_x        = rot_wx_reg[QUAT_W-1:0];
        cfg.quat_y        = rot_yz_reg[CFG_W-1:QUAT_W];
        cfg.quat_z        = rot_yz_reg[QUAT_W-1:0];
        cfg.shift_x       = shift_x_reg;
        cfg.shift_y       = shift_y_reg;
        cfg.shift_z       = shift_z_reg;
        cfg.color_floor   = floor_reg;
        cfg.color_ceiling = ceiling_reg;
    end

    // The pipeline takes a beat in every cycle.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    pthc_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .point     (point),
        .cfg       (cfg),
        .out_valid (rot_valid),
        .world     (rot_world)
    );

    pthc_height_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .world     (rot_world),
        .cfg       (cfg),
        .out_valid (col_valid),
        .result    (col_result)
    );

    assign done_next   = col_valid;
    assign result_next = col_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_DEPTH))
        else $error("result strobe without a start beat at the pipeline depth");

    // One of the two colour lanes always sits at full scale.
    a_one_full_colour: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.red_level == pthc_pkg::LEVEL_FULL ||
                  result.green_level == pthc_pkg::LEVEL_FULL))
        else $error("neither colour level is at full scale");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.coord_saturated) |->
            (result.world_x == pthc_pkg::COORD_MAX || result.world_x == pthc_pkg::COORD_MIN ||
             result.world_y == pthc_pkg::COORD_MAX || result.world_y == pthc_pkg::COORD_MIN ||
             result.world_z == pthc_pkg::COORD_MAX || result.world_z == pthc_pkg::COORD_MIN))
        else $error("saturation flag set with no coordinate at a limit");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for point_transform_height_color_unit: a directed table of
// points and register writes, then random points under random register settings.
// Depends on pthc_pkg and the unit; each result is checked by a predictor or its typed row.

module testbench;

    import pthc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_POINTS  = 200;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam logic [COORD_W-1:0]   ONE_METRE      = 32'h0001_0000;
    localparam logic [COORD_W-1:0]   MINUS_ONE_METRE = 32'hFFFF_0000;
    localparam logic [QUAT_W-1:0]    QUAT_ONE       = 16'h4000;
    localparam logic [QUAT_W-1:0]    QUAT_COS45     = 16'd11585;
    localparam longint COORD_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint COORD_LO = -64'sh0000_0000_8000_0000;

    typedef enum bit {ROW_POINT, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_value;
        point_t               pt;
        bit                   typed;
        result_t              typed_result;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    point_t               point;
    logic                 done;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    // Marks the point on the bus as carrying a hand-written expectation.
    bit                   row_typed;
    result_t              row_result;

    stim_row_t   opening_rows [$];
    result_t     awaited_results [$];
    result_t     oldest_expected;
    result_t     predicted;
    cfg_t        model_cfg;
    int unsigned cycle_count;
    int unsigned failures;
    int unsigned results_checked;
    int unsigned saturated_seen;
    int unsigned part_scale_seen;
    int unsigned writes_seen;

    point_transform_height_color_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint round_half_up(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_coord(longint x);
        if (x > COORD_HI)
            return COORD_HI;
        if (x < COORD_LO)
            return COORD_LO;
        return x;
    endfunction

    // Scale 2*num/span to 0..255, saturating at full scale; span is positive.
    function automatic logic [LEVEL_W-1:0] colour_level(longint num, longint span);
        if (num <= 0)
            return '0;
        if (2 * num >= span)
            return LEVEL_FULL;
        return LEVEL_W'((LEVEL_SCALE * num) / span);
    endfunction

    function automatic result_t transform_point(point_t p, cfg_t s);
        longint  qw, qx, qy, qz;
        longint  v [3];
        longint  cr [3];
        longint  tw [3];
        longint  rot [3];
        longint  wide [3];
        longint  flr, span, above;
        result_t r;

        qw = $signed(s.quat_w);
        qx = $signed(s.quat_x);
        qy = $signed(s.quat_y);
        qz = $signed(s.quat_z);
        v[0] = $signed(p.local_x);
        v[1] = $signed(p.local_y);
        v[2] = $signed(p.local_z);

        cr[0] = qy * v[2] - qz * v[1];
        cr[1] = qz * v[0] - qx * v[2];
        cr[2] = qx * v[1] - qy * v[0];
        for (int i = 0; i < 3; i++)
            tw[i] = round_half_up(cr[i], QUAT_FRAC - 1);

        rot[0] = qw * tw[0] + (qy * tw[2] - qz * tw[1]);
        rot[1] = qw * tw[1] + (qz * tw[0] - qx * tw[2]);
        rot[2] = qw * tw[2] + (qx * tw[1] - qy * tw[0]);

        wide[0] = v[0] + round_half_up(rot[0], QUAT_FRAC) + longint'($signed(s.shift_x));
        wide[1] = v[1] + round_half_up(rot[1], QUAT_FRAC) + longint'($signed(s.shift_y));
        wide[2] = v[2] + round_half_up(rot[2], QUAT_FRAC) + longint'($signed(s.shift_z));

        r.world_x = COORD_W'(clamp_coord(wide[0]));
        r.world_y = COORD_W'(clamp_coord(wide[1]));
        r.world_z = COORD_W'(clamp_coord(wide[2]));
        r.coord_saturated = (clamp_coord(wide[0]) != wide[0]) ||
                            (clamp_coord(wide[1]) != wide[1]) ||
                            (clamp_coord(wide[2]) != wide[2]);

        // The colour follows the exact height, not the clamped one.
        flr   = $signed(s.color_floor);
        span  = longint'($signed(s.color_ceiling)) - flr;
        above = wide[2] - flr;
        if (span <= 0)
        begin
            r.red_level   = LEVEL_FULL;
            r.green_level = '0;
        end
        else
        begin
            r.red_level   = colour_level(span - above, span);
            r.green_level = colour_level(above, span);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin
        cycle_count++;
        if (!rst_n)
        begin
            model_cfg               = '0;
            {model_cfg.quat_w, model_cfg.quat_x} = CFG_ROT_WX_RESET;
            model_cfg.color_ceiling = CFG_CEILING_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                writes_seen++;
                case (cfg_index)
                    CFG_ROT_WX:  {model_cfg.quat_w, model_cfg.quat_x} = cfg_wdata;
                    CFG_ROT_YZ:  {model_cfg.quat_y, model_cfg.quat_z} = cfg_wdata;
                    CFG_SHIFT_X: model_cfg.shift_x       = cfg_wdata;
                    CFG_SHIFT_Y: model_cfg.shift_y       = cfg_wdata;
                    CFG_SHIFT_Z: model_cfg.shift_z       = cfg_wdata;
                    CFG_FLOOR:   model_cfg.color_floor   = cfg_wdata;
                    CFG_CEILING: model_cfg.color_ceiling = cfg_wdata;
                    default:     ;
                endcase
            end

            if (start && !busy)
            begin
                predicted       = row_typed ? row_result : transform_point(point, model_cfg);
                awaited_results = {awaited_results, predicted};
            end

            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("error: result beat with nothing expected at cycle %0d",
                                 cycle_count);
                end
                else
                begin
                    oldest_expected = awaited_results.pop_front();
                    results_checked++;
                    if (oldest_expected.world_x !== result.world_x ||
                        oldest_expected.world_y !== result.world_y ||
                        oldest_expected.world_z !== result.world_z ||
                        oldest_expected.red_level !== result.red_level ||
                        oldest_expected.green_level !== result.green_level ||
                        oldest_expected.coord_saturated !== result.coord_saturated)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                        begin
                            $display("error: beat %0d expected x=%h y=%h z=%h r=%0d g=%0d sat=%b",
                                     results_checked, oldest_expected.world_x,
                                     oldest_expected.world_y, oldest_expected.world_z,
                                     oldest_expected.red_level, oldest_expected.green_level,
                                     oldest_expected.coord_saturated);
                            $display("       got      x=%h y=%h z=%h r=%0d g=%0d sat=%b",
                                     result.world_x, result.world_y, result.world_z,
                                     result.red_level, result.green_level,
                                     result.coord_saturated);
                        end
                    end
                    if (result.coord_saturated === 1'b1)
                        saturated_seen++;
                    if ((result.red_level != '0 && result.red_level != LEVEL_FULL) ||
                        (result.green_level != '0 && result.green_level != LEVEL_FULL))
                        part_scale_seen++;
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("error: timed out after %0d cycles", cycle_count);
        $display("testbench: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_point_row(point_t pt, bit typed, result_t res);
        stim_row_t row;
        row.kind         = ROW_POINT;
        row.reg_index    = '0;
        row.reg_value    = '0;
        row.pt           = pt;
        row.typed        = typed;
        row.typed_result = res;
        opening_rows     = {opening_rows, row};
    endtask

    task automatic add_write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        stim_row_t row;
        row.kind         = ROW_WRITE;
        row.reg_index    = idx;
        row.reg_value    = value;
        row.pt           = '0;
        row.typed        = 1'b0;
        row.typed_result = '0;
        opening_rows     = {opening_rows, row};
    endtask

    // Called just after a falling edge; returns just after a falling edge with start still
    // high, so that a following point goes out back to back.
    task automatic send_point(point_t pt, bit typed, result_t res);
        start      = 1'b1;
        point      = pt;
        row_typed  = typed;
        row_result = res;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic rest_sender(int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return 32'd1;
        endcase
    endfunction

    function automatic logic [QUAT_W-1:0] extreme_quat();
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            3:       return QUAT_ONE;
            default: return 16'hC000;
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t        s;
        int unsigned pick;
        s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};

        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            s.quat_w = QUAT_ONE;
            s.quat_x = '0;
            s.quat_y = '0;
            s.quat_z = '0;
        end
        else if (pick < 55)
        begin
            s.quat_w = QUAT_ONE - QUAT_W'($urandom_range(0, 4096));
            s.quat_x = $signed(s.quat_x) >>> 2;
            s.quat_y = $signed(s.quat_y) >>> 2;
            s.quat_z = $signed(s.quat_z) >>> 2;
        end
        else if (pick >= 80)
        begin
            s.quat_w = extreme_quat();
            s.quat_x = extreme_quat();
            s.quat_y = extreme_quat();
            s.quat_z = extreme_quat();
        end

        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            s.shift_x = $signed(s.shift_x) >>> 8;
            s.shift_y = $signed(s.shift_y) >>> 8;
            s.shift_z = $signed(s.shift_z) >>> 8;
        end
        else if (pick >= 85)
        begin
            s.shift_x = extreme_coord();
            s.shift_y = extreme_coord();
            s.shift_z = extreme_coord();
        end

        pick = $urandom_range(0, 99);
        s.color_floor = $signed(s.color_floor) >>> 10;
        if (pick < 60)
            s.color_ceiling = s.color_floor + COORD_W'($urandom_range(1, 1 << 22));
        else if (pick < 70)
            s.color_ceiling = s.color_floor;
        else if (pick < 85)
            s.color_ceiling = s.color_floor - COORD_W'($urandom_range(1, 1 << 22));
        else
            s.color_floor = $urandom;
        return s;
    endfunction

    function automatic point_t random_point(cfg_t s);
        point_t      p;
        longint      span, lo, z;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        p    = {$urandom, $urandom, $urandom};
        span = longint'($signed(s.color_ceiling)) - longint'($signed(s.color_floor));
        if (pick >= 90)
        begin
            p.local_x = extreme_coord();
            p.local_y = extreme_coord();
            p.local_z = extreme_coord();
        end
        else if (pick >= 50 && span > 0 && span < 64'sh4000_0000)
        begin
            // Aim the height at the colour band so that part-scale levels come up.
            lo = longint'($signed(s.color_floor)) - longint'($signed(s.shift_z)) - span / 4;
            z  = lo + longint'($urandom) % (span + span / 2 + 1);
            p.local_x = $signed(p.local_x) >>> 9;
            p.local_y = $signed(p.local_y) >>> 9;
            p.local_z = z[COORD_W-1:0];
        end
        else if (pick >= 25)
        begin
            p.local_x = $signed(p.local_x) >>> 9;
            p.local_y = $signed(p.local_y) >>> 9;
            p.local_z = $signed(p.local_z) >>> 9;
        end
        return p;
    endfunction

    initial
    begin
        stim_row_t row;
        cfg_t      s;

        rst_n      = 1'b0;
        start      = 1'b0;
        point      = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        row_typed  = 1'b0;
        row_result = '0;

        // Settings after reset: identity rotation, no shift, one-metre colour band.
        add_point_row({32'd0, 32'd0, 32'd0}, 1,
                      {32'd0, 32'd0, 32'd0, LEVEL_FULL, 8'd0, 1'b0});
        add_point_row({32'd0, 32'd0, ONE_METRE}, 1,
                      {32'd0, 32'd0, ONE_METRE, 8'd0, LEVEL_FULL, 1'b0});
        add_point_row({32'd0, 32'd0, 32'd32768}, 1,
                      {32'd0, 32'd0, 32'd32768, LEVEL_FULL, LEVEL_FULL, 1'b0});
        add_point_row({32'd0, 32'd0, 32'd16384}, 1,
                      {32'd0, 32'd0, 32'd16384, LEVEL_FULL, 8'd127, 1'b0});
        add_point_row({32'd1, 32'd1, 32'd49152}, 1,
                      {32'd1, 32'd1, 32'd49152, 8'd127, LEVEL_FULL, 1'b0});
        add_point_row({COORD_MAX, COORD_MIN, COORD_MAX}, 1,
                      {COORD_MAX, COORD_MIN, COORD_MAX, 8'd0, LEVEL_FULL, 1'b0});
        add_point_row({COORD_MIN, COORD_MAX, COORD_MIN}, 1,
                      {COORD_MIN, COORD_MAX, COORD_MIN, LEVEL_FULL, 8'd0, 1'b0});
        add_point_row({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
                      {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, LEVEL_FULL, 8'd0, 1'b0});

        // World overflow in both directions.
        add_write_row(CFG_SHIFT_X, COORD_MAX);
        add_write_row(CFG_SHIFT_Y, COORD_MIN);
        add_point_row({32'd1, 32'hFFFF_FFFF, 32'd0}, 1,
                      {COORD_MAX, COORD_MIN, 32'd0, LEVEL_FULL, 8'd0, 1'b1});
        add_point_row({32'd0, 32'd0, 32'd0}, 1,
                      {COORD_MAX, COORD_MIN, 32'd0, LEVEL_FULL, 8'd0, 1'b0});
        add_point_row({COORD_MIN, COORD_MAX, 32'd5}, 0, '0);

        // Height at the floor, then clamped below it; the colour follows the exact height.
        add_write_row(CFG_SHIFT_X, 32'd0);
        add_write_row(CFG_SHIFT_Y, 32'd0);
        add_write_row(CFG_SHIFT_Z, MINUS_ONE_METRE);
        add_point_row({32'd0, 32'd0, ONE_METRE}, 1,
                      {32'd0, 32'd0, 32'd0, LEVEL_FULL, 8'd0, 1'b0});
        add_point_row({32'd0, 32'd0, COORD_MIN}, 1,
                      {32'd0, 32'd0, COORD_MIN, LEVEL_FULL, 8'd0, 1'b1});

        // Empty band, then an inverted one at the extremes.
        add_write_row(CFG_FLOOR, ONE_METRE);
        add_point_row({32'd0, 32'd0, 32'h0003_0000}, 1,
                      {32'd0, 32'd0, 32'h0002_0000, LEVEL_FULL, 8'd0, 1'b0});
        add_write_row(CFG_FLOOR, COORD_MAX);
        add_write_row(CFG_CEILING, COORD_MIN);
        add_point_row({32'd0, 32'd0, 32'd0}, 1,
                      {32'd0, 32'd0, MINUS_ONE_METRE, LEVEL_FULL, 8'd0, 1'b0});

        // Widest possible band.
        add_write_row(CFG_FLOOR, COORD_MIN);
        add_write_row(CFG_CEILING, COORD_MAX);
        add_write_row(CFG_SHIFT_Z, 32'd0);
        add_point_row({32'd0, 32'd0, COORD_MIN}, 1,
                      {32'd0, 32'd0, COORD_MIN, LEVEL_FULL, 8'd0, 1'b0});
        add_point_row({32'd0, 32'd0, COORD_MAX}, 1,
                      {32'd0, 32'd0, COORD_MAX, 8'd0, LEVEL_FULL, 1'b0});
        add_point_row({32'd0, 32'd0, 32'd0}, 0, '0);

        // Quarter turn about z, then a badly non-unit quaternion at its extremes.
        add_write_row(CFG_ROT_WX, {QUAT_COS45, 16'd0});
        add_write_row(CFG_ROT_YZ, {16'd0, QUAT_COS45});
        add_point_row({ONE_METRE, 32'd0, 32'd0}, 0, '0);
        add_point_row({32'd0, ONE_METRE, 32'd32768}, 0, '0);
        add_point_row({COORD_MAX, COORD_MAX, COORD_MAX}, 0, '0);
        add_write_row(CFG_ROT_WX, 32'h7FFF_8000);
        add_write_row(CFG_ROT_YZ, 32'h8000_7FFF);
        add_point_row({COORD_MAX, COORD_MIN, COORD_MAX}, 0, '0);
        add_point_row({COORD_MIN, COORD_MIN, COORD_MIN}, 0, '0);
        add_point_row({32'd12345, -32'sd67890, 32'd1000}, 0, '0);

        // A write to an index past the last register must leave every register alone.
        add_write_row(CFG_UNUSED_IDX, 32'hDEAD_BEEF);
        add_point_row({ONE_METRE, ONE_METRE, ONE_METRE}, 0, '0);

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (opening_rows[i])
        begin
            row = opening_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(row.reg_index, row.reg_value);
            end
            else
                send_point(row.pt, row.typed, row.typed_result);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            s = random_settings();
            drain_results();
            write_reg(CFG_ROT_WX, {s.quat_w, s.quat_x});
            write_reg(CFG_ROT_YZ, {s.quat_y, s.quat_z});
            write_reg(CFG_SHIFT_X, s.shift_x);
            write_reg(CFG_SHIFT_Y, s.shift_y);
            write_reg(CFG_SHIFT_Z, s.shift_z);
            write_reg(CFG_FLOOR, s.color_floor);
            write_reg(CFG_CEILING, s.color_ceiling);
            for (int n = 0; n < PHASE_POINTS; n++)
            begin
                // Once, hold the sender off until the pipeline has emptied.
                if (phase == 2 && n == PHASE_POINTS / 2)
                    drain_results();
                send_point(random_point(s), 1'b0, '0);
                if (phase < RANDOM_PHASES - 1 && $urandom_range(0, 7) == 0)
                    rest_sender($urandom_range(1, 15));
            end
        end

        drain_results();
        repeat (PIPE_DEPTH + 8) @(negedge clk);

        $display("summary: %0d result beats checked, %0d register writes, %0d clamped,",
                 results_checked, writes_seen, saturated_seen);
        $display("summary: %0d with part-scale colour, %0d failures",
                 part_scale_seen, failures);
        if (failures == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/pthc_pkg.sv
design/pthc_rotate.sv
design/pthc_level_div.sv
design/pthc_height_color.sv
design/point_transform_height_color_unit.sv
tb/testbench.sv
